// ----- rtl/core/lis_pkg.sv -----
package lis_pkg;

  localparam int DefaultMaxLength = 256;
  localparam int ValueWidth       = 32;
  localparam int LengthWidth      = 9;

  typedef logic signed [ValueWidth-1:0] value_t;

  // Broadcast from the top level to every cell in the chain.
  typedef struct packed {
    logic   take;
    value_t key;
  } lis_bcast_t;

endpackage

// ----- rtl/core/lis_cell.sv -----
module lis_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 9
) (
  input  logic                clk,
  input  lis_pkg::lis_bcast_t bcast,
  input  logic [CNT_W-1:0]    fill,
  input  logic                ge_prev,
  output logic                ge,
  output logic                wr
);
  import lis_pkg::*;

  localparam logic [CNT_W-1:0] MyIndex = CNT_W'(INDEX);

  value_t tail;
  logic   used;
  logic   at_end;

  assign used   = MyIndex < fill;
  assign at_end = MyIndex == fill;

  // The table is sorted, so the ge flags of the cells in use form a run of
  // zeros followed by ones; the first one is the replacement point.
  assign ge = used && (tail >= bcast.key);
  assign wr = bcast.take && (ge || at_end) && !ge_prev;

  always_ff @(posedge clk) begin
    if (wr) begin
      tail <= bcast.key;
    end
  end

endmodule

// ----- rtl/core/longest_increasing_subsequence.sv -----
// Streaming longest strictly increasing subsequence length.
// Input channel: value (signed 32 bit) and last, with in_valid / in_stall.
// Output channel: length, overflow and end_of_sequence, with out_valid /
// out_stall. Every input item gives exactly one output item.
// An item is taken in one cycle and its result appears in the output
// register on the next cycle; the block takes one item per cycle while no
// waiting result is held by out_stall. The rate is set by the compare that every cell of the
// chain makes against the incoming value in the same cycle.
// While a result waits in the output register and out_stall is high, in_stall
// is raised and no new item is taken; once the result is taken, the next
// item may be accepted in that same cycle.
// An item with last set reports its own length and then clears the count and
// the overflow flag for the next sequence. overflow stays set once an append
// was dropped on a full table, until the end of the sequence.
// Reset clears the count, the overflow flag and the output valid flag; the
// cell contents need no reset because only cells below the count are used.
module longest_increasing_subsequence #(
  parameter int MAX_LENGTH = lis_pkg::DefaultMaxLength
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [lis_pkg::ValueWidth-1:0] value,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lis_pkg::LengthWidth-1:0]   length,
  output logic                              overflow,
  output logic                              end_of_sequence
);
  import lis_pkg::*;

  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam logic [CNT_W-1:0] FullCount = CNT_W'(MAX_LENGTH);

  logic [CNT_W-1:0]      fill_count;
  logic [CNT_W-1:0]      fill_count_next;
  logic                  overflow_seen;
  logic                  overflow_seen_next;
  logic                  take;
  logic                  any_ge;
  logic                  append;
  logic                  drop;
  logic [MAX_LENGTH-1:0] ge;
  logic [MAX_LENGTH-1:0] wr;
  lis_bcast_t            bcast;

  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  assign bcast.take = take;
  assign bcast.key  = value;

  genvar i;
  generate
    for (i = 0; i < MAX_LENGTH; i++) begin : g_cell
      if (i == 0) begin : g_first
        lis_cell #(.INDEX(i), .CNT_W(CNT_W)) u_cell (
          .clk     (clk),
          .bcast   (bcast),
          .fill    (fill_count),
          .ge_prev (1'b0),
          .ge      (ge[i]),
          .wr      (wr[i])
        );
      end else begin : g_rest
        lis_cell #(.INDEX(i), .CNT_W(CNT_W)) u_cell (
          .clk     (clk),
          .bcast   (bcast),
          .fill    (fill_count),
          .ge_prev (ge[i-1]),
          .ge      (ge[i]),
          .wr      (wr[i])
        );
      end
    end
  endgenerate

  assign any_ge = |ge;
  assign append = !any_ge && (fill_count != FullCount);
  assign drop   = !any_ge && (fill_count == FullCount);

  always_comb begin
    fill_count_next    = fill_count + CNT_W'(append);
    overflow_seen_next = overflow_seen || drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        if (last) begin
          fill_count    <= '0;
          overflow_seen <= 1'b0;
        end else begin
          fill_count    <= fill_count_next;
          overflow_seen <= overflow_seen_next;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      length          <= LengthWidth'(fill_count_next);
      overflow        <= overflow_seen_next;
      end_of_sequence <= last;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FullCount)
    else $error("fill count above table size");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0(wr))
    else $error("more than one cell written for one item");

  a_write_or_drop: assert property (@(posedge clk) disable iff (rst)
    take && !drop |-> $countones(wr) == 1)
    else $error("accepted item wrote no cell");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    take && last |=> fill_count == '0 && !overflow_seen)
    else $error("sequence state not cleared after last item");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> fill_count == FullCount)
    else $error("overflow flag set on a table that is not full");
`endif

endmodule

// ----- tb/sv/tb_longest_increasing_subsequence.sv -----
`timescale 1ns / 1ps

module tb_longest_increasing_subsequence;

  import lis_pkg::*;

  localparam int Depth = DefaultMaxLength;
  localparam int LongHoldCycles = 60;
  localparam int TargetItems = 750;
  localparam int SteadyFrom = 650;

  typedef enum int {SeqWide, SeqNarrow, SeqRising} seq_flavor_t;

  typedef struct packed {
    logic [LengthWidth-1:0] length;
    logic                   overflow;
    logic                   end_of_sequence;
  } lis_result_t;

  // Keeps its own copy of the tail table and the queue of predicted results.
  class lis_tracker;
    int          depth;
    value_t      tails[$];
    logic        overflow_seen;
    lis_result_t expected_q[$];
    int          errors;
    int          items;
    int          sequences;
    int          peak_length;
    int          overflow_results;

    function new(int table_depth);
      depth = table_depth;
      overflow_seen = 1'b0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Patience-sorting step: replace the first tail that is not below the
    // value, or append when none is and the table is not full; else flag overflow.
    function void note_item(value_t v, logic end_mark);
      int          pos;
      lis_result_t r;
      pos = tails.size();
      for (int i = 0; i < tails.size(); i++) begin
        if (tails[i] >= v) begin
          pos = i;
          break;
        end
      end
      if (pos < tails.size()) begin
        tails[pos] = v;
      end else if (tails.size() < depth) begin
        tails.insert(tails.size(), v);
      end else begin
        overflow_seen = 1'b1;
      end
      r.length = LengthWidth'(tails.size());
      r.overflow = overflow_seen;
      r.end_of_sequence = end_mark;
      expected_q.insert(expected_q.size(), r);
      items++;
      if (tails.size() > peak_length) peak_length = tails.size();
      if (overflow_seen) overflow_results++;
      if (end_mark) begin
        tails.delete();
        overflow_seen = 1'b0;
        sequences++;
      end
    endfunction

    function void check_result(logic [LengthWidth-1:0] len, logic ovf, logic eos);
      lis_result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: length %0d overflow %0b end %0b",
                 $time, len, ovf, eos);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (len !== r.length) begin
        $display("%0t: length expected %0d, got %0d", $time, r.length, len);
        errors++;
      end
      if (ovf !== r.overflow) begin
        $display("%0t: overflow expected %0b, got %0b", $time, r.overflow, ovf);
        errors++;
      end
      if (eos !== r.end_of_sequence) begin
        $display("%0t: end_of_sequence expected %0b, got %0b", $time,
                 r.end_of_sequence, eos);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  value_t                 value;
  logic                   last;
  logic                   out_valid;
  logic                   out_stall;
  logic [LengthWidth-1:0] length;
  logic                   overflow;
  logic                   end_of_sequence;

  lis_tracker tracker;
  bit         steady;
  bit         hold_req;
  int         items_sent;

  longest_increasing_subsequence #(
    .MAX_LENGTH(Depth)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .length(length),
    .overflow(overflow),
    .end_of_sequence(end_of_sequence)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_longest_increasing_subsequence: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.note_item(value, last);
      if (out_valid && !out_stall) tracker.check_result(length, overflow, end_of_sequence);
    end
  end

  // Receiver: open stretches, random stall bursts, and one long hold on request.
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input value_t v, input logic end_mark);
    in_valid <= 1'b1;
    value <= v;
    last <= end_mark;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (items_sent >= SteadyFrom) steady = 1'b1;
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_sequence(input int n, input seq_flavor_t flavor);
    value_t v;
    value_t cur;
    cur = -value_t'($urandom_range(0, 1 << 20));
    for (int i = 0; i < n; i++) begin
      case (flavor)
        SeqWide: begin
          v = value_t'($urandom);
        end
        SeqNarrow: begin
          v = value_t'($urandom_range(0, 15)) - 8;
        end
        default: begin
          // Mostly rising with equal steps and the odd dip to or below the tail.
          if ($urandom_range(0, 5) == 0) begin
            v = cur - value_t'($urandom_range(0, 64));
          end else begin
            cur = cur + value_t'($urandom_range(0, 64));
            v = cur;
          end
        end
      endcase
      send_item(v, i == n - 1);
    end
  endtask

  // Strictly rising run longer than the table, with dips that replace tails
  // before the table fills.
  task automatic run_overflow_sequence();
    value_t cur;
    cur = value_t'(32'h8000_0000) + value_t'($urandom_range(0, 1000));
    for (int i = 0; i < 270; i++) begin
      if (i % 37 == 36) begin
        send_item(cur - value_t'($urandom_range(1, 4096)), 1'b0);
      end else begin
        cur = cur + value_t'($urandom_range(1, 4096));
        send_item(cur, i == 269);
      end
    end
  endtask

  initial begin
    int seq_count;
    tracker = new(Depth);
    rst <= 1'b1;
    in_valid <= 1'b0;
    value <= '0;
    last <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(value_t'(0), 1'b1);
    send_item(value_t'(32'h8000_0000), 1'b0);
    send_item(value_t'(32'h7fff_ffff), 1'b0);
    send_item(value_t'(32'h7fff_ffff), 1'b0);
    send_item(value_t'(32'h8000_0000), 1'b0);
    send_item(value_t'(-1), 1'b0);
    send_item(value_t'(0), 1'b0);
    send_item(value_t'(0), 1'b0);
    send_item(value_t'(1), 1'b0);
    send_item(value_t'(2), 1'b1);
    for (int i = 5; i >= 1; i--) send_item(value_t'(i), i == 1);
    send_item(value_t'(32'h5555_5555), 1'b0);
    send_item(value_t'(32'haaaa_aaaa), 1'b0);
    send_item(value_t'(32'hffff_ffff), 1'b0);
    send_item(value_t'(32'h0000_0001), 1'b1);

    seq_count = 0;
    while (items_sent < TargetItems) begin
      if (seq_count == 3) hold_req = 1'b1;
      if (seq_count == 6) begin
        drain_results();
        run_overflow_sequence();
      end
      run_sequence($urandom_range(1, 40), seq_flavor_t'($urandom_range(0, 2)));
      seq_count++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d items in %0d sequences; longest run %0d, %0d results with overflow.",
             tracker.items, tracker.sequences, tracker.peak_length, tracker.overflow_results);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("tb_longest_increasing_subsequence: clean");
    end else begin
      $display("tb_longest_increasing_subsequence: errors");
    end
    $finish;
  end

endmodule
